>>> rtl/sirs_pkg.sv
`timescale 1ns / 1ps

package sirs_pkg;

  localparam int unsigned SIRS_MAX_BASE = 16;
  localparam int unsigned NUM_W         = 32;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned BASE_LEN_W    = 5;
  localparam int unsigned SYMS_W        = 64;
  localparam int unsigned STEP_BITS     = 4;
  localparam int unsigned DIV_STEPS     = NUM_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned MAX_DIGITS    = NUM_W;
  localparam int unsigned DCNT_W        = $clog2(MAX_DIGITS) + 1;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  typedef struct packed {
    logic               done;
    logic [NUM_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  // Symbol byte for a digit value: low word holds digits 0..7, high word 8..15.
  function automatic logic [SYM_W-1:0] sym_of(input logic [SYMS_W-1:0]  lo,
                                              input logic [SYMS_W-1:0]  hi,
                                              input logic [DIGIT_W-1:0] d);
    logic [SYMS_W-1:0] word;
    begin
      word   = d[DIGIT_W-1] ? hi : lo;
      sym_of = word[d[DIGIT_W-2:0]*SYM_W +: SYM_W];
    end
  endfunction

endpackage

>>> rtl/sirs_base_chk.sv
`timescale 1ns / 1ps

module sirs_base_chk import sirs_pkg::*; #(
  parameter int unsigned MAX_BASE = SIRS_MAX_BASE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [BASE_LEN_W-1:0] base_len_i,
  input  logic [SYMS_W-1:0]     symbols_low_i,
  input  logic [SYMS_W-1:0]     symbols_high_i,
  output chk_status_t           status_o
);

  localparam int unsigned IDX_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

  logic             busy_q;
  logic             bad_q;
  logic [IDX_W-1:0] idx_q;

  logic [SYM_W-1:0] cur_sym;
  logic             hit;
  logic             at_end;
  logic             done;

  // Check one symbol per cycle against the forbidden bytes and all later symbols.
  always_comb begin
    cur_sym = sym_of(symbols_low_i, symbols_high_i, DIGIT_W'(idx_q));
    hit = (cur_sym == '0) || (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS);
    for (int unsigned j = 0; j < MAX_BASE; j++) begin
      if ((BASE_LEN_W'(j) > BASE_LEN_W'(idx_q)) && (BASE_LEN_W'(j) < base_len_i) &&
          (sym_of(symbols_low_i, symbols_high_i, DIGIT_W'(j)) == cur_sym)) begin
        hit = 1'b1;
      end
    end
  end

  assign at_end = (BASE_LEN_W'(idx_q) == (base_len_i - BASE_LEN_W'(1)));
  assign done   = busy_q && (bad_q || hit || at_end);

  assign status_o.done = done;
  assign status_o.ok   = !bad_q && !hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      bad_q  <= (base_len_i < BASE_LEN_W'(2)) || (base_len_i > BASE_LEN_W'(MAX_BASE));
    end else if (busy_q) begin
      if (done) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

endmodule

>>> rtl/sirs_div.sv
`timescale 1ns / 1ps

module sirs_div import sirs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      dividend_i,
  input  logic [BASE_LEN_W-1:0] radix_i,
  output div_res_t              res_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]      shreg_q, shreg_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;

  logic [BASE_LEN_W-1:0] part;
  logic [STEP_BITS-1:0]  qbits;

  // Restoring division, STEP_BITS quotient bits per cycle. The remainder
  // stays below the radix, so it fits a digit.
  always_comb begin
    rem_d = rem_q;
    qbits = '0;
    part  = '0;
    for (int unsigned b = 0; b < STEP_BITS; b++) begin
      part = {rem_d, shreg_q[NUM_W-1-b]};
      if (part >= radix_i) begin
        rem_d = DIGIT_W'(part - radix_i);
        qbits[STEP_BITS-1-b] = 1'b1;
      end else begin
        rem_d = part[DIGIT_W-1:0];
      end
    end
    shreg_d = {shreg_q[NUM_W-STEP_BITS-1:0], qbits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_CNT_W'(DIV_STEPS - 1));
      if (busy_q) begin
        cnt_q <= cnt_q + STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= dividend_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = shreg_q;
  assign res_o.rem  = rem_q;

endmodule

>>> rtl/signed_int_to_radix_symbols_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------
// input    | in        | in_valid_i / in_stall_o   | number_i
// output   | out       | out_valid_o / out_stall_i | symbol_o, last_o
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Per number: the base symbols are checked in turn (up to MAX_BASE), then each digit
// comes from the shared shift-subtract divider (4 quotient bits a cycle), then
// one symbol goes out per cycle unless the output stalls.
// Reset clears control state and the configuration registers to zero.
// A stall on the output holds the emitting sequencer; the next number is taken
// while the final symbol of the previous one still waits in the output register.
module signed_int_to_radix_symbols_top import sirs_pkg::*; #(
  parameter int unsigned MAX_BASE = SIRS_MAX_BASE
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [NUM_W-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SYM_W-1:0]        symbol_o,
  output logic                    last_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [SYMS_W-1:0]       cfg_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam int unsigned PTR_W = DCNT_W - 1;

  logic [1:0]            state_q, state_d;
  logic [BASE_LEN_W-1:0] base_len_q;
  logic [SYMS_W-1:0]     sym_lo_q;
  logic [SYMS_W-1:0]     sym_hi_q;
  logic                  neg_q, neg_d;
  logic [NUM_W-1:0]      mag_q;
  logic [DCNT_W-1:0]     nd_q, nd_d;
  logic [DIGIT_W-1:0]    stack_q [MAX_DIGITS];
  logic                  out_valid_q, out_valid_d;
  logic [SYM_W-1:0]      symbol_q, symbol_d;
  logic                  last_q, last_d;

  logic                  in_xfer;
  logic                  out_free;
  logic                  push;
  logic                  chk_start;
  logic                  div_start;
  logic [NUM_W-1:0]      div_operand;
  logic [PTR_W-1:0]      top_ptr;
  chk_status_t           chk_st;
  div_res_t              div_res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  // hold off register writes while a number is offered so the two never share an edge
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign chk_start   = in_xfer;
  assign top_ptr     = PTR_W'(nd_q - DCNT_W'(1));

  sirs_base_chk #(
    .MAX_BASE(MAX_BASE)
  ) u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (chk_start),
    .base_len_i    (base_len_q),
    .symbols_low_i (sym_lo_q),
    .symbols_high_i(sym_hi_q),
    .status_o      (chk_st)
  );

  sirs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_operand),
    .radix_i   (base_len_q),
    .res_o     (div_res)
  );

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    nd_d        = nd_q;
    push        = 1'b0;
    div_start   = 1'b0;
    div_operand = mag_q;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CHECK;
          neg_d   = number_i[NUM_W-1];
          nd_d    = '0;
        end
      end
      S_CHECK: begin
        if (chk_st.done) begin
          if (chk_st.ok) begin
            state_d   = S_DIV;
            div_start = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          push = 1'b1;
          nd_d = nd_q + DCNT_W'(1);
          if (div_res.quot != '0) begin
            div_start   = 1'b1;
            div_operand = div_res.quot;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            // sign goes out ahead of the digits
            symbol_d = SYM_MINUS;
            last_d   = 1'b0;
            neg_d    = 1'b0;
          end else begin
            symbol_d = sym_of(sym_lo_q, sym_hi_q, stack_q[top_ptr]);
            last_d   = (nd_q == DCNT_W'(1));
            nd_d     = nd_q - DCNT_W'(1);
            if (nd_q == DCNT_W'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
      base_len_q  <= '0;
      sym_lo_q    <= '0;
      sym_hi_q    <= '0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_BASE_LEN:     base_len_q <= cfg_data_i[BASE_LEN_W-1:0];
          CFG_SYMBOLS_LOW:  sym_lo_q   <= cfg_data_i;
          CFG_SYMBOLS_HIGH: sym_hi_q   <= cfg_data_i;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    symbol_q <= symbol_d;
    last_q   <= last_d;
    if (in_xfer) begin
      // two's complement negate; the most negative value maps to its magnitude
      mag_q <= number_i[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number_i)) : NUM_W'(number_i);
    end
    if (push) begin
      stack_q[nd_q[PTR_W-1:0]] <= div_res.rem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_digit_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= DCNT_W'(MAX_DIGITS))
    else $error("digit count exceeds the stack depth");

  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> nd_q != '0)
    else $error("emitting with an empty digit stack");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_chk_done_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_st.done |-> state_q == S_CHECK)
    else $error("base check finished outside the check phase");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sirs_pkg::*;

  localparam logic [SYMS_W-1:0] HEX_LO = 64'h3736_3534_3332_3130;  // "01234567"
  localparam logic [SYMS_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;  // "89ABCDEF"
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 1000;
  localparam int RANDOM_ITEMS  = 420;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } sym_beat_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [SYMS_W-1:0]    data;
    logic [NUM_W-1:0]     num;
    bit                   typed;
    string                text;
  } script_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [NUM_W-1:0] number_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [SYM_W-1:0]        symbol_o;
  logic                    last_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [SYMS_W-1:0]       cfg_data_i;

  // Mirror of the configuration registers
  logic [BASE_LEN_W-1:0] cur_base_len;
  logic [SYMS_W-1:0]     cur_syms_lo;
  logic [SYMS_W-1:0]     cur_syms_hi;

  sym_beat_t   awaited_symbols[$];
  script_row_t script[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          errors;

  signed_int_to_radix_symbols_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [SYM_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
    logic [2*SYMS_W-1:0] tbl;
    tbl = {cur_syms_hi, cur_syms_lo};
    return tbl[d*SYM_W +: SYM_W];
  endfunction

  function automatic bit radix_usable();
    logic [SYM_W-1:0] s;
    int i;
    int j;
    if (cur_base_len < 2 || cur_base_len > SIRS_MAX_BASE) return 1'b0;
    for (i = 0; i < cur_base_len; i++) begin
      s = digit_symbol(DIGIT_W'(i));
      if (s == 8'h00 || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (j = i + 1; j < cur_base_len; j++)
        if (digit_symbol(DIGIT_W'(j)) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_radix_symbols(input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0]   mag;
    logic [NUM_W-1:0]   rdx;
    logic [DIGIT_W-1:0] digs[MAX_DIGITS];
    int                 nd;
    int                 i;
    if (!radix_usable()) return;
    rdx = NUM_W'(cur_base_len);
    mag = n[NUM_W-1] ? -n : n;  // most negative value stays 2^31 as unsigned
    nd  = 0;
    do begin
      digs[nd] = DIGIT_W'(mag % rdx);
      mag      = mag / rdx;
      nd++;
    end while (mag != 0);
    if (n[NUM_W-1]) awaited_symbols.push_back('{SYM_MINUS, 1'b0});
    for (i = nd - 1; i >= 0; i--)
      awaited_symbols.push_back('{digit_symbol(digs[i]), i == 0});
  endfunction

  function automatic void queue_text_symbols(input string text);
    int i;
    for (i = 0; i < text.len(); i++)
      awaited_symbols.push_back('{SYM_W'(text[i]), i == text.len() - 1});
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SYMS_W-1:0] data);
    script_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.num    = '0;
    r.typed  = 1'b0;
    r.text   = "";
    script.push_back(r);
  endfunction

  function automatic void add_num(input logic [NUM_W-1:0] n, input bit typed,
                                  input string text);
    script_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.data   = '0;
    r.num    = n;
    r.typed  = typed;
    r.text   = text;
    script.push_back(r);
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = NUM_W'($urandom_range(0, 40));
      1: v = -NUM_W'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      3: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SYMS_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BASE_LEN:     cur_base_len = data[BASE_LEN_W-1:0];
      CFG_SYMBOLS_LOW:  cur_syms_lo  = data;
      CFG_SYMBOLS_HIGH: cur_syms_hi  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold valid across back-to-back transfers; drop it only on an idle cycle.
  task automatic offer_number(input logic [NUM_W-1:0] n, input bit typed, input string text);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (typed) queue_text_symbols(text);
    else queue_radix_symbols(n);
    in_valid_i <= 1'b1;
    number_i   <= n;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // An invalid base gives no symbols, so wait out the block's own latency too.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sym_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_symbols.size() == 0) begin
        errors++;
        $display("%0t: extra symbol, expected none, actual symbol %h last %b",
                 $time, symbol_o, last_o);
      end else begin
        want = awaited_symbols.pop_front();
        if (symbol_o !== want.sym) begin
          errors++;
          $display("%0t: symbol mismatch, expected %h actual %h", $time, want.sym, symbol_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  initial begin
    logic [SYM_W-1:0]      syms[SIRS_MAX_BASE];
    bit                    used[256];
    logic [BASE_LEN_W-1:0] radix;
    logic [SYMS_W-1:0]     lo;
    logic [SYMS_W-1:0]     hi;
    logic [SYMS_W-1:0]     len_word;
    logic [SYM_W-1:0]      b;
    int                    valid_items;
    int                    phase;
    int                    n_items;
    int                    p;
    int                    q;
    int                    i;
    bit                    usable;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    number_i      = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_BASE_LEN;
    cfg_data_i    = '0;
    cur_base_len  = '0;
    cur_syms_lo   = '0;
    cur_syms_hi   = '0;
    hold_req      = 1'b0;
    errors        = 0;
    send_idle_pct = 34;
    recv_idle_pct = 67;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset base, hex extremes, binary worst case, decimal, broken bases
    add_num(32'd5, 1'b1, "");
    add_reg(CFG_SYMBOLS_LOW, HEX_LO);
    add_reg(CFG_SYMBOLS_HIGH, HEX_HI);
    add_reg(CFG_BASE_LEN, 64'd16);
    add_num(32'd0, 1'b1, "0");
    add_num(32'd1, 1'b1, "1");
    add_num(32'hFFFF_FFFF, 1'b1, "-1");
    add_num(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
    add_num(32'h8000_0000, 1'b1, "-80000000");
    add_num(32'd255, 1'b1, "FF");
    add_num(-32'sd16, 1'b1, "-10");
    add_reg(CFG_BASE_LEN, 64'd2);
    add_num(32'h8000_0000, 1'b1, {"-1", "0000000000", "0000000000", "0000000000", "0"});
    add_num(32'h7FFF_FFFF, 1'b1, {"1111111111", "1111111111", "1111111111", "1"});
    add_num(32'hFFFF_FFFF, 1'b1, "-1");
    add_num(32'd0, 1'b1, "0");
    add_reg(CFG_BASE_LEN, 64'd10);
    add_num(-32'sd123456789, 1'b0, "");
    add_num(32'h7FFF_FFFF, 1'b1, "2147483647");
    add_num(32'h8000_0000, 1'b1, "-2147483648");
    add_reg(CFG_BASE_LEN, 64'd1);
    add_num(32'd7, 1'b1, "");
    add_reg(CFG_BASE_LEN, 64'd17);
    add_num(-32'sd7, 1'b1, "");
    add_reg(CFG_BASE_LEN, 64'd31);
    add_num(32'd1, 1'b1, "");
    add_reg(CFG_BASE_LEN, 64'd16);
    add_reg(CFG_SYMBOLS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_num(32'd100, 1'b1, "");
    add_reg(CFG_SYMBOLS_HIGH, 64'h0045_4443_4241_3938);
    add_num(-32'sd100, 1'b1, "");
    add_reg(CFG_BASE_LEN, 64'd15);
    add_num(32'd12345, 1'b0, "");
    add_reg(CFG_BASE_LEN, 64'd16);
    add_reg(CFG_SYMBOLS_HIGH, HEX_HI);
    add_reg(CFG_SYMBOLS_LOW, 64'h3736_352B_3332_3130);
    add_num(32'd9, 1'b1, "");
    add_reg(CFG_SYMBOLS_LOW, 64'h3736_352D_3332_3130);
    add_num(32'd9, 1'b1, "");

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        if (k == 0 || !script[k-1].is_reg) settle_block();
        write_reg(script[k].idx, script[k].data);
      end else begin
        offer_number(script[k].num, script[k].typed, script[k].text);
      end
    end

    valid_items = 0;
    phase       = 0;
    while (valid_items < RANDOM_ITEMS) begin
      if (valid_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 67;
      end else if (valid_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle_block();

      // Build a table of distinct usable symbols, then maybe break it.
      foreach (used[j]) used[j] = 1'b0;
      used[0]         = 1'b1;
      used[SYM_PLUS]  = 1'b1;
      used[SYM_MINUS] = 1'b1;
      for (i = 0; i < SIRS_MAX_BASE; i++) begin
        do b = SYM_W'($urandom_range(1, 255)); while (used[b]);
        used[b] = 1'b1;
        syms[i] = b;
      end
      case ($urandom_range(0, 7))
        0:       radix = 5'd2;
        1:       radix = 5'd16;
        default: radix = BASE_LEN_W'($urandom_range(2, 16));
      endcase
      // Slots past the radix are ignored by the check
      for (i = radix; i < SIRS_MAX_BASE; i++) begin
        case ($urandom_range(0, 3))
          0: syms[i] = 8'h00;
          1: syms[i] = SYM_PLUS;
          2: syms[i] = syms[0];
          default: ;
        endcase
      end
      if ($urandom_range(0, 6) == 0) begin
        p = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 5))
          0: syms[p] = 8'h00;
          1: syms[p] = SYM_PLUS;
          2: syms[p] = SYM_MINUS;
          3: begin
            do q = $urandom_range(0, radix - 1); while (q == p);
            syms[p] = syms[q];
          end
          4: radix = BASE_LEN_W'($urandom_range(0, 1));
          default: radix = BASE_LEN_W'($urandom_range(17, 31));
        endcase
      end
      for (i = 0; i < 8; i++) begin
        lo[i*SYM_W +: SYM_W] = syms[i];
        hi[i*SYM_W +: SYM_W] = syms[i+8];
      end
      len_word = {$urandom(), $urandom()};
      len_word[BASE_LEN_W-1:0] = radix;
      write_reg(CFG_SYMBOLS_LOW, lo);
      write_reg(CFG_SYMBOLS_HIGH, hi);
      write_reg(CFG_BASE_LEN, len_word);

      usable = radix_usable();
      if (phase == 1 || phase == 6) hold_req = 1'b1;
      n_items = usable ? $urandom_range(20, 60) : 4;
      for (i = 0; i < n_items; i++) offer_number(pick_number(), 1'b0, "");
      if (usable) valid_items += n_items;
      phase++;
    end

    settle_block();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> signed_int_to_radix_symbols_top.f
rtl/sirs_pkg.sv
rtl/sirs_base_chk.sv
rtl/sirs_div.sv
rtl/signed_int_to_radix_symbols_top.sv
tb/sv/testbench.sv
